FILE: design/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int C_DATA_W     = 32;
    localparam int C_CHAR_W     = 6;
    localparam int C_NUM_DIGITS = 10;
    localparam int C_BCD_W      = 4 * C_NUM_DIGITS;
    localparam int C_CNT_W      = $clog2(C_DATA_W);
    localparam int C_LEFT_W     = $clog2(C_NUM_DIGITS + 1);

    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = C_CHAR_W'(48);
    localparam logic [C_CHAR_W-1:0] C_CHAR_MINUS = C_CHAR_W'(45);

    typedef logic [C_DATA_W-1:0] t_value;
    typedef logic [C_CHAR_W-1:0] t_char;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_zero;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic last_digit;
        logic negative;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: design/sbda_if.sv
// ----------------------------------------------------------------------------
// sbda_in_if / sbda_out_if
// Valid/ready channels carrying the input integer and the output characters.
// ----------------------------------------------------------------------------
interface sbda_in_if;
    logic            valid;
    logic            ready;
    sbda_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
    logic            valid;
    logic            ready;
    sbda_pkg::t_char out_char;
    logic            last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

FILE: design/signed_binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Converts a 32-bit two's-complement integer to decimal ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one transaction carries a 32-bit signed value.
//   o_out : one transaction per character, most significant first; a minus
//           sign leads negative values, leading zeros are dropped, zero gives
//           a single '0'. last marks the final character of the number.
// Timing:
//   After acceptance the magnitude goes through the shift-add-3 BCD loop,
//   then the dropped leading zeros (up to 9) are shifted out one by one,
//   then one character per cycle moves into the output register while
//   o_out is not stalled.
//   One number is worked on at a time; i_in.ready is high only while idle.
//   The next number is accepted while the final character still waits.
// Reset: synchronous, active low; returns to idle and clears o_out.valid.
// Stall: when o_out.ready is low the character is held and emission pauses.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbda_in_if.sink           i_in,
    sbda_out_if.source        o_out
);
    import sbda_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sbda_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    sbda_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_in.value),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_char  (o_out.out_char),
        .o_out_last  (o_out.last)
    );

endmodule

FILE: design/sbda_datapath.sv
// ----------------------------------------------------------------------------
// sbda_datapath
// Magnitude register, shift-add-3 BCD converter and output character register.
// ----------------------------------------------------------------------------
module sbda_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbda_pkg::t_dp_cmd i_cmd,
    output sbda_pkg::t_dp_sts o_sts,
    input  sbda_pkg::t_value  i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sbda_pkg::t_char   o_out_char,
    output logic              o_out_last
);
    import sbda_pkg::*;

    logic [C_DATA_W-1:0]  r_bin;
    logic [C_BCD_W-1:0]   r_bcd;
    logic                 r_neg;
    logic [C_CNT_W-1:0]   r_cnt;
    logic [C_LEFT_W-1:0]  r_left;
    logic                 r_out_valid;
    t_char                r_out_char;
    logic                 r_out_last;

    logic [C_BCD_W-1:0]   adj;
    logic [3:0]           top_nib;

    always_comb begin
        for (int k = 0; k < C_NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    assign top_nib = r_bcd[C_BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_value[C_DATA_W-1] ? (C_DATA_W'(0) - i_value) : i_value;
            r_neg  <= i_value[C_DATA_W-1];
            r_bcd  <= '0;
            r_cnt  <= '0;
            r_left <= C_LEFT_W'(C_NUM_DIGITS);
        end else if (i_cmd.conv_step) begin
            {r_bcd, r_bin} <= {adj[C_BCD_W-2:0], r_bin, 1'b0};
            r_cnt          <= r_cnt + 1'b1;
        end else if (i_cmd.skip_zero || i_cmd.emit_digit) begin
            r_bcd  <= {r_bcd[C_BCD_W-5:0], 4'd0};
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= C_CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= C_CHAR_ZERO + {{(C_CHAR_W-4){1'b0}}, top_nib};
            r_out_last <= (r_left == C_LEFT_W'(1));
        end
    end

    assign o_sts.conv_done  = (r_cnt == C_CNT_W'(C_DATA_W - 1));
    assign o_sts.top_zero   = (top_nib == 4'd0);
    assign o_sts.last_digit = (r_left == C_LEFT_W'(1));
    assign o_sts.negative   = r_neg;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

FILE: design/sbda_controller.sv
// ----------------------------------------------------------------------------
// sbda_controller
// Sequences load, conversion, leading-zero skip and character emission.
// ----------------------------------------------------------------------------
module sbda_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output sbda_pkg::t_dp_cmd o_cmd,
    input  sbda_pkg::t_dp_sts i_sts
);
    import sbda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_in_ready = 1'b1;
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                    n_in_ready = 1'b0;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_sts.top_zero && !i_sts.last_digit) begin
                    o_cmd.skip_zero = 1'b1;
                end else if (i_sts.negative) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state    = ST_IDLE;
                        n_in_ready = 1'b1;
                    end
                end
            end
            default: begin
                n_state    = ST_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

FILE: design/sbda_checker.sv
// ----------------------------------------------------------------------------
// sbda_checker
// Port-level checks for the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
module sbda_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input sbda_pkg::t_char i_out_char,
    input logic            i_out_last
);
    import sbda_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == C_CHAR_MINUS) ||
                        (i_out_char >= C_CHAR_ZERO && i_out_char <= C_CHAR_ZERO + 6'd9))
        else $error("illegal output character");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_char == C_CHAR_MINUS |-> !i_out_last)
        else $error("minus sign flagged as last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while converting");

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last)
);
